// ----- design/top_k_score_selector_top_defines.svh -----
// Assertion macros for the top-k score selector.
// Depends on nothing; taken in by the files that carry assertions.
`ifndef TOP_K_SCORE_SELECTOR_TOP_DEFINES_SVH
`define TOP_K_SCORE_SELECTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TKSEL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TKSEL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tksel_pkg.sv -----
// Shared types, codes and the entry ordering of the top-k score selector.
// Depends on nothing.
package tksel_pkg;

  localparam int SCORE_W = 32;
  localparam int ID_W    = 15;
  localparam int RANK_W  = 6;
  localparam int KEEP_W  = 6;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    item_id;
  } cmd_t;

  typedef struct packed {
    logic [SCORE_W-1:0] out_score;
    logic [ID_W-1:0]    out_id;
    logic [RANK_W-1:0]  rank;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
  } entry_t;

  // a ranks strictly worse than b: lower score, or equal score and larger id
  function automatic logic is_worse(entry_t a, entry_t b);
    if (a.score == b.score) begin
      return a.id > b.id;
    end
    return a.score < b.score;
  endfunction

endpackage

// ----- design/tksel_heap_ram.sv -----
// Heap storage: one write port, two registered read ports.
// Depends on tksel_pkg for the entry type.
module tksel_heap_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  tksel_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output tksel_pkg::entry_t rdata0,
  output tksel_pkg::entry_t rdata1
);
  import tksel_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- design/tksel_ctrl.sv -----
// Sequencer for heap insert, removal and drain over the heap RAM.
// Depends on tksel_pkg; drives the ports of tksel_heap_ram.
module tksel_ctrl #(
  parameter int MAX_KEEP = 63
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  tksel_pkg::cmd_t          cmd,
  input  logic [$clog2(MAX_KEEP+2)-1:0] eff_keep,
  output logic                     busy,
  output logic                     result_valid,
  output tksel_pkg::result_t       result,
  output logic [$clog2(MAX_KEEP+2)-1:0] entry_count,
  output logic                     mem_we,
  output logic [$clog2(MAX_KEEP+1)-1:0] mem_waddr,
  output tksel_pkg::entry_t        mem_wdata,
  output logic [$clog2(MAX_KEEP+1)-1:0] mem_raddr0,
  output logic [$clog2(MAX_KEEP+1)-1:0] mem_raddr1,
  input  tksel_pkg::entry_t        mem_rdata0,
  input  tksel_pkg::entry_t        mem_rdata1
);
  import tksel_pkg::*;

  localparam int AW  = $clog2(MAX_KEEP + 1);
  localparam int CW  = $clog2(MAX_KEEP + 2);
  localparam int CHW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_UP, S_PUT, S_CHECK, S_POP0, S_POP1, S_DOWN
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [AW-1:0]   pos;
  logic [CHW-1:0]  child;
  entry_t          key;
  logic            draining;
  logic            popping;

  entry_t          new_entry;
  logic [AW-1:0]   par_cnt;
  logic [AW-1:0]   par_pos;
  logic [AW-1:0]   par_up;
  logic            up_move;
  logic            has_right;
  logic            pick_right;
  logic [CHW-1:0]  sel;
  entry_t          cval;
  logic            down_move;
  logic [CHW-1:0]  nchild;
  logic            nchild_in;

  assign new_entry   = '{score: cmd.score, id: cmd.item_id};
  assign par_cnt     = AW'((count - 1'b1) >> 1);
  assign par_pos     = (pos - 1'b1) >> 1;
  assign par_up      = (par_pos - 1'b1) >> 1;
  assign up_move     = !is_worse(mem_rdata0, key);
  assign has_right   = (child + 1'b1) < CHW'(count);
  assign pick_right  = has_right && !is_worse(mem_rdata0, mem_rdata1);
  assign sel         = pick_right ? child + 1'b1 : child;
  assign cval        = pick_right ? mem_rdata1 : mem_rdata0;
  assign down_move   = !is_worse(key, cval);
  assign nchild      = {sel[CHW-2:0], 1'b1};
  assign nchild_in   = nchild < CHW'(count);

  assign busy        = (state != S_IDLE);
  assign entry_count = count;

  // memory port control
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = pos;
    mem_wdata  = key;
    mem_raddr0 = '0;
    mem_raddr1 = '0;
    case (state)
      S_IDLE: begin
        if (start && cmd.mode == MODE_INSERT) begin
          if (count == '0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = new_entry;
          end else begin
            mem_raddr0 = par_cnt;
          end
        end
      end
      S_UP: begin
        mem_we = 1'b1;
        if (up_move) begin
          mem_wdata  = mem_rdata0;
          mem_raddr0 = par_up;
        end
      end
      S_PUT: begin
        mem_we = 1'b1;
      end
      S_POP0: begin
        mem_raddr0 = '0;
        mem_raddr1 = AW'(count - 1'b1);
      end
      S_POP1: begin
        mem_raddr0 = AW'(1);
        mem_raddr1 = AW'(2);
      end
      S_DOWN: begin
        mem_we = 1'b1;
        if (down_move) begin
          mem_wdata  = cval;
          mem_raddr0 = AW'(nchild);
          mem_raddr1 = AW'(nchild + 1'b1);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      draining     <= 1'b0;
      popping      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          popping <= 1'b0;
          if (start) begin
            if (cmd.mode == MODE_INSERT) begin
              key      <= new_entry;
              count    <= count + 1'b1;
              draining <= 1'b0;
              pos      <= AW'(count);
              state    <= (count == '0) ? S_CHECK : S_UP;
            end else if (count != '0) begin
              draining <= 1'b1;
              state    <= S_POP0;
            end
          end
        end
        S_UP: begin
          if (up_move) begin
            pos   <= par_pos;
            state <= (par_pos == '0) ? S_PUT : S_UP;
          end else begin
            state <= S_CHECK;
          end
        end
        S_PUT: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (popping) begin
            state <= (draining && count != '0) ? S_POP0 : S_IDLE;
          end else if (count > eff_keep) begin
            state <= S_POP0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_POP0: begin
          popping <= 1'b1;
          count   <= count - 1'b1;
          state   <= S_POP1;
        end
        S_POP1: begin
          key   <= mem_rdata1;
          pos   <= '0;
          child <= CHW'(1);
          if (draining) begin
            result_valid     <= 1'b1;
            result.out_score <= mem_rdata0.score;
            result.out_id    <= mem_rdata0.id;
            result.rank      <= RANK_W'(count + 1'b1);
            result.last      <= (count == '0);
          end
          state <= (count > CW'(1)) ? S_DOWN : S_PUT;
        end
        S_DOWN: begin
          if (down_move) begin
            pos   <= AW'(sel);
            child <= nchild;
            state <= nchild_in ? S_DOWN : S_PUT;
          end else begin
            state <= S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/top_k_score_selector_top.sv -----
// Top-k score selector: the keep-count register, the heap RAM and its sequencer.
// Depends on tksel_pkg, tksel_heap_ram, tksel_ctrl and the assertion macro header.
//
// Keeps the best keep_count (score, item_id) pairs in a binary min-heap whose
// root is the worst kept entry; lower score is worse, and on equal scores the
// larger id is worse. A command word is taken when start is high and busy is
// low. An insert word sifts the pair up one heap level per cycle; if the count
// then exceeds the effective keep count, the root is dropped and the last entry
// sifts down, again one level per cycle with both children read together. A
// sift walks at most 6 heap levels with 63 entries. A drain word pops every
// kept entry worst first: each pop ends in one result word, strobed by
// result_valid for exactly one cycle with its rank (entry count before the
// pop, 1 = best) and last set on the final pop. The receiver cannot stall;
// result words leave at the pop rate and must be caught as they go. A drain on
// an empty heap gives no word and returns to idle at once. The single heap RAM
// write port sets the pace: one level is committed per cycle. keep_count is
// written through cfg_we/cfg_wdata while busy is low; zero acts as one and
// values above MAX_KEEP saturate. The heap RAM needs no clearing after reset.
`include "top_k_score_selector_top_defines.svh"

module top_k_score_selector_top #(
  parameter int MAX_KEEP = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tksel_pkg::cmd_t    cmd,
  output logic               busy,
  output logic               result_valid,
  output tksel_pkg::result_t result,
  input  logic               cfg_we,
  input  logic [5:0]         cfg_wdata
);
  import tksel_pkg::*;

  localparam int AW    = $clog2(MAX_KEEP + 1);
  localparam int CW    = $clog2(MAX_KEEP + 2);
  localparam int DEPTH = MAX_KEEP + 1;

  logic [KEEP_W-1:0] keep_count;
  logic [CW-1:0]     eff_keep;
  logic [CW-1:0]     entry_count;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [AW-1:0]     mem_raddr0;
  logic [AW-1:0]     mem_raddr1;
  entry_t            mem_rdata0;
  entry_t            mem_rdata1;

  // hold the keep count; the user writes it only while idle, not enforced here
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_W'(63);
    end else if (cfg_we) begin
      keep_count <= cfg_wdata;
    end
  end

  // clamp to 1..MAX_KEEP
  always_comb begin
    if (keep_count == '0) begin
      eff_keep = CW'(1);
    end else if ({1'b0, keep_count} > (KEEP_W+1)'(MAX_KEEP)) begin
      eff_keep = CW'(MAX_KEEP);
    end else begin
      eff_keep = CW'(keep_count);
    end
  end

  tksel_heap_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (mem_rdata0),
    .rdata1 (mem_rdata1)
  );

  tksel_ctrl #(
    .MAX_KEEP (MAX_KEEP)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .eff_keep     (eff_keep),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .entry_count  (entry_count),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr0   (mem_raddr0),
    .mem_raddr1   (mem_raddr1),
    .mem_rdata0   (mem_rdata0),
    .mem_rdata1   (mem_rdata1)
  );

  // results come only out of a drain in progress
  `TKSEL_ASSERT_NOW(a_result_in_work, clk, rst, result_valid, busy, "result word while idle")
  // the final pop leaves the heap empty
  `TKSEL_ASSERT_NOW(a_last_empties, clk, rst, result_valid && result.last, entry_count == '0, "last pop with entries left")
  // at rest the heap never holds more than MAX_KEEP entries
  `TKSEL_ASSERT_NOW(a_count_bound, clk, rst, !busy, entry_count <= CW'(MAX_KEEP), "entry count over capacity")
  // an accepted insert always occupies the sequencer
  `TKSEL_ASSERT_NEXT(a_insert_busy, clk, rst, start && !busy && cmd.mode == MODE_INSERT, busy, "insert not started")

endmodule

// ----- bench/top_k_score_selector_top_test.sv -----
// Self-checking bench for the top-k score selector: directed words, then random traffic.
// Depends on tksel_pkg and top_k_score_selector_top; carries its own heap predictor.
`timescale 1ns / 100ps

module top_k_score_selector_top_test;
  import tksel_pkg::*;

  localparam int MAX_KEEP      = 63;
  localparam int HEAP_DEPTH    = 64;
  // Wait this long before touching the keep-count register after a run of
  // inserts, so that a trailing insert with its removal can finish.
  localparam int SETTLE_CYCLES = 30;
  // Limit for the whole run, with ample margin over the slowest correct run.
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_WORDS   = 84;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    result_valid;
  result_t result;
  logic    cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;

  top_k_score_selector_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a copy of the heap, its fill level and the keep register.
  entry_t     kept_heap [HEAP_DEPTH];
  int         kept_count = 0;
  logic [5:0] keep_setting = 6'd63;
  result_t    pending_pops [$];

  int fail_count  = 0;
  int words_taken = 0;
  int cycle_count = 0;
  int idle_pct    = 0;

  // A directed row may carry its expected pops typed in; this overrides the
  // predictor's output for that word while the predictor state still advances.
  bit      typed_on = 1'b0;
  int      typed_n  = 0;
  result_t typed_res = '0;

  typedef struct {
    bit         is_cfg;
    logic [5:0] keep;
    cmd_t       word;
    int         typed_n;   // -1: predictor decides
    result_t    typed;
  } stim_row_t;

  stim_row_t stim_rows [$];

  // Lower score is worse; on a score tie the larger id is worse.
  function automatic bit ranks_below(entry_t a, entry_t b);
    return (a.score < b.score) || ((a.score == b.score) && (a.id > b.id));
  endfunction

  function automatic int effective_keep();
    int k;
    k = keep_setting;
    if (k < 1) k = 1;
    if (k > MAX_KEEP) k = MAX_KEEP;
    return k;
  endfunction

  task automatic heap_insert(entry_t e);
    int pos;
    int up;
    bit done;
    if (kept_count >= HEAP_DEPTH) return;
    pos = kept_count;
    kept_count++;
    done = 1'b0;
    while (!done && pos > 0) begin
      up = (pos - 1) / 2;
      if (!ranks_below(kept_heap[up], e)) begin
        kept_heap[pos] = kept_heap[up];
        pos = up;
      end else begin
        done = 1'b1;
      end
    end
    kept_heap[pos] = e;
  endtask

  task automatic heap_drop_root();
    int pos;
    int child;
    entry_t tail;
    bit done;
    if (kept_count == 0) return;
    kept_count--;
    tail = kept_heap[kept_count];
    pos = 0;
    child = 1;
    done = 1'b0;
    while (!done && child < kept_count) begin
      if (child + 1 < kept_count && !ranks_below(kept_heap[child], kept_heap[child + 1])) begin
        child++;
      end
      if (!ranks_below(tail, kept_heap[child])) begin
        kept_heap[pos] = kept_heap[child];
        pos = child;
        child = 2 * pos + 1;
      end else begin
        done = 1'b1;
      end
    end
    kept_heap[pos] = tail;
  endtask

  // Advance the heap copy by one command word and queue the pops it causes.
  task automatic apply_word(cmd_t c);
    entry_t e;
    result_t r;
    int n;
    if (c.mode == MODE_INSERT) begin
      e.score = c.score;
      e.id = c.item_id;
      heap_insert(e);
      if (kept_count > effective_keep()) heap_drop_root();
    end else begin
      n = 0;
      while (kept_count > 0 && n < MAX_KEEP) begin
        r.out_score = kept_heap[0].score;
        r.out_id = kept_heap[0].id;
        r.rank = kept_count[5:0];
        heap_drop_root();
        r.last = (kept_count == 0);
        pending_pops.push_back(r);
        n++;
      end
    end
  endtask

  // Sample at the rising edge: check result words, catch taken command words
  // and register writes. All inputs move at the falling edge, so nothing here
  // races the drive side.
  always @(posedge clk) begin : monitor
    result_t want;
    int q0;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (!rst) begin
      if (result_valid) begin
        if (pending_pops.size() == 0) begin
          $error("result word with no pop pending: score %h id %h", result.out_score,
                 result.out_id);
          fail_count++;
        end else begin
          want = pending_pops.pop_front();
          if (result.out_score !== want.out_score) begin
            $error("out_score expected %h got %h", want.out_score, result.out_score);
            fail_count++;
          end
          if (result.out_id !== want.out_id) begin
            $error("out_id expected %h got %h", want.out_id, result.out_id);
            fail_count++;
          end
          if (result.rank !== want.rank) begin
            $error("rank expected %0d got %0d", want.rank, result.rank);
            fail_count++;
          end
          if (result.last !== want.last) begin
            $error("last expected %b got %b", want.last, result.last);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        words_taken++;
        q0 = pending_pops.size();
        apply_word(cmd);
        if (typed_on) begin
          while (pending_pops.size() > q0) void'(pending_pops.pop_back());
          for (int i = 0; i < typed_n; i++) pending_pops.push_back(typed_res);
        end
      end
      if (cfg_we) keep_setting = cfg_wdata;
    end
  end

  // Offer one command word and hold it until taken; then maybe idle a while.
  // Called and returns at a falling edge. Unless an idle gap follows, start stays high into the next word.
  task automatic send_word(cmd_t c);
    int taken0;
    int gap;
    logic [63:0] junk;
    start = 1'b1;
    cmd = c;
    taken0 = words_taken;
    @(negedge clk);
    while (words_taken == taken0) @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      junk = {$urandom, $urandom};
      start = 1'b0;
      cmd = junk[47:0];
      gap = $urandom_range(1, 30);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Write keep_count only once the block is idle: drain all pending pops,
  // let any trailing insert finish, then wait for busy to drop.
  task automatic write_keep(logic [5:0] v);
    start = 1'b0;
    while (pending_pops.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_wdata = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic row_cfg(logic [5:0] v);
    stim_row_t row;
    row = '{is_cfg: 1'b1, keep: v, word: '0, typed_n: -1, typed: '0};
    stim_rows.push_back(row);
  endtask

  task automatic row_insert(logic [31:0] s, logic [14:0] id);
    stim_row_t row;
    row = '{is_cfg: 1'b0, keep: '0, word: '{mode: MODE_INSERT, score: s, item_id: id},
            typed_n: -1, typed: '0};
    stim_rows.push_back(row);
  endtask

  // n = -1 leaves the pops to the predictor; 0 or 1 types them in.
  task automatic row_drain(int n, result_t r);
    stim_row_t row;
    row = '{is_cfg: 1'b0, keep: '0, word: '{mode: MODE_DRAIN, score: 32'hA5A5_5A5A,
            item_id: 15'h2D2D}, typed_n: n, typed: r};
    stim_rows.push_back(row);
  endtask

  // Random insert word; some flavors crowd scores and ids to force ties.
  function automatic cmd_t random_insert();
    cmd_t c;
    c.mode = MODE_INSERT;
    case ($urandom_range(0, 3))
      0: begin
        c.score = $urandom;
        c.item_id = 15'($urandom_range(0, 32767));
      end
      1: begin
        c.score = {14'h0, 2'($urandom_range(0, 3)), 16'h0};
        c.item_id = 15'($urandom_range(0, 7));
      end
      2: begin
        case ($urandom_range(0, 3))
          0: c.score = 32'h0000_0000;
          1: c.score = 32'hFFFF_FFFF;
          2: c.score = 32'h8000_0000;
          default: c.score = 32'h7FFF_FFFF;
        endcase
        c.item_id = 15'($urandom_range(0, 32767));
      end
      default: begin
        c.score = $urandom_range(0, 15);
        c.item_id = 15'($urandom_range(0, 3));
      end
    endcase
    return c;
  endfunction

  function automatic cmd_t random_drain();
    cmd_t c;
    c.mode = MODE_DRAIN;
    c.score = $urandom;
    c.item_id = 15'($urandom_range(0, 32767));
    return c;
  endfunction

  function automatic logic [5:0] random_keep();
    case ($urandom_range(0, 4))
      0: return 6'd0;
      1: return 6'd63;
      2: return 6'd1;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin : stimulus
    int phase_sent;
    int burst;
    int phase_idle [3];
    phase_idle = '{11, 83, 0};

    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed part. Typed rows: empty drains, and single survivors at keep
    // count one (zero acts as one; the better of two pairs stays).
    row_drain(0, '0);
    row_cfg(6'd63);
    row_insert(32'hFFFF_FFFF, 15'h7FFF);
    row_insert(32'h0000_0000, 15'h0000);
    row_drain(-1, '0);
    row_cfg(6'd0);
    row_insert(32'd5, 15'd3);
    row_insert(32'd9, 15'd1);
    row_drain(1, '{out_score: 32'd9, out_id: 15'd1, rank: 6'd1, last: 1'b1});
    row_drain(0, '0);
    row_cfg(6'd63);
    // equal scores, equal ids, and an identical pair inserted twice
    row_insert(32'h0001_0000, 15'd7);
    row_insert(32'h0001_0000, 15'd2);
    row_insert(32'h0001_0000, 15'd7);
    row_insert(32'h8000_0000, 15'h4000);
    row_insert(32'h7FFF_FFFF, 15'h3FFF);
    // keep count lowered below the fill level: inserts shed only one root each
    row_cfg(6'd2);
    row_insert(32'd3, 15'd3);
    row_insert(32'hFFFF_FFFF, 15'd0);
    row_drain(-1, '0);
    row_cfg(6'd1);
    row_insert(32'h5555_5555, 15'h2AAA);
    row_insert(32'hAAAA_AAAA, 15'h5555);
    row_drain(1, '{out_score: 32'hAAAA_AAAA, out_id: 15'h5555, rank: 6'd1, last: 1'b1});
    row_cfg(6'd63);

    idle_pct = phase_idle[0];
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        write_keep(stim_rows[i].keep);
      end else begin
        typed_on = (stim_rows[i].typed_n >= 0);
        typed_n = stim_rows[i].typed_n;
        typed_res = stim_rows[i].typed;
        send_word(stim_rows[i].word);
      end
    end
    typed_on = 1'b0;

    // Random part: runs of inserts closed by a drain, under three idle rates.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = phase_idle[phase];
      phase_sent = 0;
      while (phase_sent < PHASE_WORDS) begin
        if ($urandom_range(0, 3) == 0) write_keep(random_keep());
        if ($urandom_range(0, 9) == 0) begin
          burst = $urandom_range(30, 70);
        end else begin
          burst = $urandom_range(0, 12);
        end
        // hold the word count of a phase near its budget
        if (burst > PHASE_WORDS - phase_sent) burst = PHASE_WORDS - phase_sent;
        for (int j = 0; j < burst; j++) begin
          send_word(random_insert());
          phase_sent++;
        end
        send_word(random_drain());
        phase_sent++;
        // an occasional back-to-back drain hits the empty heap
        if ($urandom_range(0, 5) == 0) begin
          send_word(random_drain());
          phase_sent++;
        end
      end
    end

    // Hold off, let the last drain finish, then give a final settling margin.
    start = 1'b0;
    while (pending_pops.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
